### sv/srnt_pkg.sv
// Shared types and constants for the sorted radix node table.
// Used by srnt_cell, sorted_radix_node_table and its testbench; no dependencies.
package srnt_pkg;

   localparam int ENTRIES    = 16;
   localparam int CHILD_BITS = 48;
   localparam int IDX_W      = $clog2(ENTRIES);
   localparam int CNT_W      = $clog2(ENTRIES + 1);

   // external field widths, fixed by the stream format
   localparam int OP_W     = 3;
   localparam int KEY_W    = 8;
   localparam int XCHILD_W = 48;
   localparam int STAT_W   = 2;

   typedef enum logic [OP_W-1:0] {
      OP_INSERT = 3'd0,
      OP_LOOKUP = 3'd1,
      OP_CHANGE = 3'd2,
      OP_REMOVE = 3'd3,
      OP_RANGE  = 3'd4
   } op_type;

   typedef enum logic [STAT_W-1:0] {
      ST_DONE      = 2'd0,
      ST_FULL      = 2'd1,
      ST_DUPLICATE = 2'd2,
      ST_NOT_FOUND = 2'd3
   } status_type;

   // broadcast to every cell
   typedef struct packed {
      logic                  ins_go;
      logic                  rem_go;
      logic                  chg_go;
      logic [KEY_W-1:0]      key;
      logic [CHILD_BITS-1:0] child;
      logic [CNT_W-1:0]      count;
   } cell_ctl_type;

   // what a cell hands to its neighbours
   typedef struct packed {
      logic [KEY_W-1:0]      key;
      logic [CHILD_BITS-1:0] child;
      logic                  gt;    // used and key > search key
      logic                  ge;    // used and key >= search key
   } cell_link_type;

   // per-cell flags gathered by the top level
   typedef struct packed {
      logic eq;        // used and key == search key
      logic pred_sel;  // this cell is the predecessor for a range check
   } cell_flags_type;

endpackage

### sv/srnt_cell.sv
// One slot of the sorted node: key and child register with compare and
// neighbour shift logic. Depends on srnt_pkg.
module srnt_cell
   import srnt_pkg::*;
(
   input  logic           clock,
   input  logic [IDX_W-1:0] slot_idx,
   input  cell_ctl_type   ctl,
   input  cell_link_type  left_link,
   input  cell_link_type  right_link,
   output cell_link_type  link,
   output cell_flags_type flags
);

   logic [KEY_W-1:0]      key_ff, key_in;
   logic [CHILD_BITS-1:0] child_ff, child_in;
   logic [CNT_W-1:0]      idx_ext, idx_next;
   logic                  used, gt, ge, eq;

   assign idx_ext  = CNT_W'(slot_idx);
   assign idx_next = idx_ext + CNT_W'(1);
   assign used     = idx_ext < ctl.count;
   assign gt       = used && (key_ff > ctl.key);
   assign ge       = used && (key_ff >= ctl.key);
   assign eq       = used && (key_ff == ctl.key);

   assign link.key   = key_ff;
   assign link.child = child_ff;
   assign link.gt    = gt;
   assign link.ge    = ge;

   assign flags.eq = eq;
   // ascending keys: first entry from index 1 up with key >= search key
   // sits just right of this one
   assign flags.pred_sel = right_link.ge && ((slot_idx == '0) || !ge);

   always_comb begin
      key_in   = key_ff;
      child_in = child_ff;
      if (ctl.ins_go) begin
         if (left_link.gt) begin
            key_in   = left_link.key;
            child_in = left_link.child;
         end else if (gt || (idx_ext == ctl.count)) begin
            key_in   = ctl.key;
            child_in = ctl.child;
         end
      end else if (ctl.rem_go) begin
         // matched key exists, so cells with key >= search key are the
         // removed slot and everything after it
         if (ge && (idx_next < ctl.count)) begin
            key_in   = right_link.key;
            child_in = right_link.child;
         end
      end else if (ctl.chg_go && eq) begin
         child_in = ctl.child;
      end
   end

   always_ff @(posedge clock) begin
      key_ff   <= key_in;
      child_ff <= child_in;
   end

endmodule

### sv/sorted_radix_node_table.sv
// Top level of the sorted radix node table: stream ports, row of cells,
// result register. Depends on srnt_pkg and srnt_cell.
//
// A byte-keyed radix tree node of up to ENTRIES entries kept in ascending
// key order, one entry per cell in a row of ENTRIES cells. Every cell
// compares its key with the request key at once; inserts shift the tail one
// cell right, removes shift it one cell left, each cell taking from its
// neighbour. One request is handled per clock while responses are taken:
// it is accepted, applied to the cells and its response loaded into the
// output register in the same cycle, so the sustained rate is one transfer
// per cycle. The response is registered and appears in the cycle after the
// request transfer. A new request is taken whenever the output
// register is empty or its response is being taken. Slots never written
// hold no defined value but are never read: only the first entry_count
// cells take part in any compare.
module sorted_radix_node_table
   import srnt_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   // request: [2:0] operation, [10:3] key, [58:11] child_in, rest zero
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [63:0] req_tdata,
   // response: [1:0] status, [49:2] child_out, [50] has_smaller,
   // [51] has_bigger, [56:52] entry_count, rest zero
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [63:0] rsp_tdata
);

   op_type                op;
   logic [KEY_W-1:0]      req_key;
   logic [CHILD_BITS-1:0] req_child;
   logic                  req_xfer;

   logic [CNT_W-1:0]      count_ff, count_in;
   cell_ctl_type          ctl;
   cell_link_type         link [ENTRIES];
   cell_flags_type        flags [ENTRIES];

   logic                  any_eq, any_ge, full;
   logic [CHILD_BITS-1:0] eq_child, pred_child;

   logic                  rsp_valid_ff, rsp_valid_in;
   status_type            status_ff, status_in;
   logic [CHILD_BITS-1:0] child_ff, child_in;
   logic                  smaller_ff, smaller_in;
   logic                  bigger_ff, bigger_in;
   logic [CNT_W-1:0]      cnt_out_ff;

   assign op        = op_type'(req_tdata[2:0]);
   assign req_key   = req_tdata[10:3];
   assign req_child = CHILD_BITS'(req_tdata[58:11]);

   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign req_xfer   = req_tvalid && req_tready;

   assign full = count_ff >= CNT_W'(ENTRIES);

   assign ctl.key    = req_key;
   assign ctl.child  = req_child;
   assign ctl.count  = count_ff;
   assign ctl.ins_go = req_xfer && (op == OP_INSERT) && !full && !any_eq;
   assign ctl.rem_go = req_xfer && (op == OP_REMOVE) && any_eq;
   assign ctl.chg_go = req_xfer && (op == OP_CHANGE) && any_eq;

   // row of cells; the ends see an empty neighbour
   for (genvar g = 0; g < ENTRIES; g++) begin : g_cell
      cell_link_type left_l, right_l;
      if (g == 0) begin : g_first
         assign left_l = '0;
      end else begin : g_inner_l
         assign left_l = link[g-1];
      end
      if (g == ENTRIES - 1) begin : g_last
         assign right_l = '0;
      end else begin : g_inner_r
         assign right_l = link[g+1];
      end
      srnt_cell u_cell (
         .clock      (clock),
         .slot_idx   (IDX_W'(g)),
         .ctl        (ctl),
         .left_link  (left_l),
         .right_link (right_l),
         .link       (link[g]),
         .flags      (flags[g])
      );
   end

   // gather match flags and one-hot child selects across the row;
   // any_ge: some used key is >= the request key
   always_comb begin
      any_eq     = 1'b0;
      any_ge     = 1'b0;
      eq_child   = '0;
      pred_child = '0;
      for (int i = 0; i < ENTRIES; i++) begin
         any_eq = any_eq | flags[i].eq;
         any_ge = any_ge | link[i].ge;
         if (flags[i].eq) eq_child = eq_child | link[i].child;
         if (flags[i].pred_sel) pred_child = pred_child | link[i].child;
      end
   end

   always_comb begin
      count_in = count_ff;
      if (ctl.ins_go) count_in = count_ff + CNT_W'(1);
      else if (ctl.rem_go) count_in = count_ff - CNT_W'(1);
   end

   always_comb begin
      status_in  = ST_DONE;
      child_in   = '0;
      smaller_in = 1'b0;
      bigger_in  = 1'b0;
      case (op)
         OP_INSERT: begin
            if (full) status_in = ST_FULL;
            else if (any_eq) status_in = ST_DUPLICATE;
         end
         OP_LOOKUP: begin
            if (any_eq) child_in = eq_child;
            else status_in = ST_NOT_FOUND;
         end
         OP_CHANGE, OP_REMOVE: begin
            if (!any_eq) status_in = ST_NOT_FOUND;
         end
         OP_RANGE: begin
            if (count_ff != '0) begin
               if (link[0].gt) begin
                  bigger_in = 1'b1;
               end else if (!any_ge) begin
                  smaller_in = 1'b1;
               end else begin
                  smaller_in = 1'b1;
                  bigger_in  = 1'b1;
                  child_in   = (count_ff == CNT_W'(1)) ? link[0].child : pred_child;
               end
            end
         end
         default: ;
      endcase
   end

   assign rsp_valid_in = req_xfer || (rsp_valid_ff && !rsp_tready);

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // response payload, loaded on each request transfer
   always_ff @(posedge clock) begin
      if (req_xfer) begin
         status_ff  <= status_in;
         child_ff   <= child_in;
         smaller_ff <= smaller_in;
         bigger_ff  <= bigger_in;
         cnt_out_ff <= count_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {7'd0, 5'(cnt_out_ff), bigger_ff, smaller_ff,
                        XCHILD_W'(child_ff), status_ff};

endmodule

### verif/sorted_radix_node_table_test.sv
// Self-checking testbench for sorted_radix_node_table: drives node operations over the
// request stream and checks every response against a predictor of the sorted node.
// Depends on srnt_pkg and the sorted_radix_node_table RTL.
module sorted_radix_node_table_test
   import srnt_pkg::*;
();

   localparam int CYCLE_LIMIT = 500000;
   localparam int DRAIN_CYCLES = 16;
   localparam logic [XCHILD_W-1:0] CHILD_MASK =
      (CHILD_BITS >= XCHILD_W) ? '1 : XCHILD_W'((64'd1 << CHILD_BITS) - 1);

   // one response as the node should report it
   typedef struct packed {
      status_type            status;
      logic [XCHILD_W-1:0]   child;
      logic                  smaller;
      logic                  bigger;
      logic [4:0]            count;
   } node_result_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [63:0] req_tdata = '0;   // [2:0] operation, [10:3] key, [58:11] child_in
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [63:0] rsp_tdata;       // [1:0] status, [49:2] child_out, [50] has_smaller,
                                 // [51] has_bigger, [56:52] entry_count

   // predictor state: sorted keys and their children, slots below node_used valid
   logic [KEY_W-1:0]    node_keys[ENTRIES];
   logic [XCHILD_W-1:0] node_children[ENTRIES];
   int                  node_used = 0;

   node_result_type pending_results[$];
   int              fail_count = 0;
   int              cycle_count = 0;
   bit              idling_on = 1'b1;
   int              stall_left = 0;

   sorted_radix_node_table dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   initial begin
      forever #1 clock = ~clock;
   end

   // slot holding an exact match, or -1
   function automatic int find_key(input logic [KEY_W-1:0] key);
      for (int i = 0; i < node_used; i++)
         if (node_keys[i] == key) return i;
      return -1;
   endfunction

   // apply one operation to the predicted node and return the response it gives
   function automatic node_result_type apply_node_op(input op_type op,
                                                     input logic [KEY_W-1:0] key,
                                                     input logic [XCHILD_W-1:0] child_in);
      node_result_type res;
      logic [XCHILD_W-1:0] child;
      int slot;
      int i;
      res = '0;
      res.status = ST_DONE;
      child = child_in & CHILD_MASK;
      case (op)
         OP_INSERT: begin
            if (node_used >= ENTRIES) begin
               res.status = ST_FULL;            // fullness wins over duplicate
            end else if (find_key(key) >= 0) begin
               res.status = ST_DUPLICATE;
            end else begin
               i = node_used;
               while (i > 0 && node_keys[i-1] > key) begin
                  node_keys[i] = node_keys[i-1];
                  node_children[i] = node_children[i-1];
                  i--;
               end
               node_keys[i] = key;
               node_children[i] = child;
               node_used++;
            end
         end
         OP_LOOKUP: begin
            slot = find_key(key);
            if (slot < 0) res.status = ST_NOT_FOUND;
            else res.child = node_children[slot];
         end
         OP_CHANGE: begin
            slot = find_key(key);
            if (slot < 0) res.status = ST_NOT_FOUND;
            else node_children[slot] = child;
         end
         OP_REMOVE: begin
            slot = find_key(key);
            if (slot < 0) begin
               res.status = ST_NOT_FOUND;
            end else begin
               for (i = slot; i + 1 < node_used; i++) begin
                  node_keys[i] = node_keys[i+1];
                  node_children[i] = node_children[i+1];
               end
               node_used--;
            end
         end
         OP_RANGE: begin
            if (node_used > 0) begin
               if (node_keys[0] > key) begin
                  res.bigger = 1'b1;
               end else if (node_keys[node_used-1] < key) begin
                  res.smaller = 1'b1;
               end else begin
                  res.smaller = 1'b1;
                  res.bigger = 1'b1;
                  // predecessor: child before the first key >= search key from
                  // slot 1 on; a lone entry or no such key picks first/last
                  if (node_used == 1) begin
                     res.child = node_children[0];
                  end else begin
                     res.child = node_children[node_used-1];
                     for (i = 1; i < node_used; i++)
                        if (node_keys[i] >= key) begin
                           res.child = node_children[i-1];
                           break;
                        end
                  end
               end
            end
         end
         default: ;  // unused codes leave the node alone
      endcase
      res.count = node_used[4:0];
      return res;
   endfunction

   // one request transfer; the prediction is made at the accepting edge
   task automatic send_request(input op_type op, input logic [KEY_W-1:0] key,
                               input logic [XCHILD_W-1:0] child);
      int gap;
      if (idling_on && $urandom_range(0, 3) == 0) begin
         gap = $urandom_range(1, 10);
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {5'b0, child, key, op};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      pending_results.push_back(apply_node_op(op, key, child));
   endtask

   function automatic logic [XCHILD_W-1:0] random_child();
      logic [63:0] raw;
      int pick;
      raw = {$urandom, $urandom};
      pick = $urandom_range(0, 9);
      if (pick == 0) return '0;
      if (pick == 1) return '1;
      return raw[XCHILD_W-1:0];
   endfunction

   // mostly stored keys and their neighbours, so hits and range edges are common
   function automatic logic [KEY_W-1:0] pick_key();
      logic [KEY_W-1:0] k;
      int pick;
      pick = $urandom_range(0, 99);
      if (node_used == 0 || pick < 25) return KEY_W'($urandom);
      k = node_keys[$urandom_range(0, node_used - 1)];
      if (pick < 85) return k;
      return (pick < 92) ? k + 1'b1 : k - 1'b1;
   endfunction

   task automatic note_mismatch(input string field, input logic [63:0] want,
                                input logic [63:0] got);
      fail_count++;
      if (fail_count <= 10)
         $display("mismatch in %s at cycle %0d: expected %0h, got %0h",
                  field, cycle_count, want, got);
   endtask

   // response side stalls in bursts while idling is on
   always @(posedge clock) begin
      if (idling_on && stall_left > 0) begin
         stall_left--;
         rsp_tready <= 1'b0;
      end else if (idling_on && $urandom_range(0, 7) == 0) begin
         stall_left = $urandom_range(1, 10) - 1;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   // compare each response transfer with the oldest prediction
   always @(posedge clock) begin
      node_result_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_results.size() == 0) begin
            note_mismatch("unexpected response", 64'd0, rsp_tdata);
         end else begin
            want = pending_results.pop_front();
            if (rsp_tdata[1:0] !== want.status)
               note_mismatch("status", want.status, rsp_tdata[1:0]);
            if (rsp_tdata[49:2] !== want.child)
               note_mismatch("child_out", want.child, rsp_tdata[49:2]);
            if (rsp_tdata[50] !== want.smaller)
               note_mismatch("has_smaller", want.smaller, rsp_tdata[50]);
            if (rsp_tdata[51] !== want.bigger)
               note_mismatch("has_bigger", want.bigger, rsp_tdata[51]);
            if (rsp_tdata[56:52] !== want.count)
               note_mismatch("entry_count", want.count, rsp_tdata[56:52]);
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("TEST FAILED");
         $finish;
      end
   end

   // hand-picked corners: empty node, lone entry, extreme keys and children,
   // duplicates, misses and removal at both ends
   task automatic test_directed();
      send_request(OP_RANGE,  8'h80, '0);          // empty node: no flags
      send_request(OP_LOOKUP, 8'h00, '0);
      send_request(OP_CHANGE, 8'hff, '1);
      send_request(OP_REMOVE, 8'h10, '0);
      send_request(OP_INSERT, 8'h80, '1);
      send_request(OP_RANGE,  8'h80, '0);          // lone entry gives its child
      send_request(OP_RANGE,  8'h7f, '0);          // below all keys
      send_request(OP_RANGE,  8'h81, '0);          // above all keys
      send_request(OP_INSERT, 8'h00, '0);          // null child stored as is
      send_request(OP_INSERT, 8'hff, 48'h5555_5555_5555);
      send_request(OP_INSERT, 8'h80, 48'h1234_5678_9abc);  // duplicate
      send_request(OP_LOOKUP, 8'h00, '0);
      send_request(OP_LOOKUP, 8'hff, '0);
      send_request(OP_LOOKUP, 8'h40, '0);          // miss
      send_request(OP_RANGE,  8'h40, '0);          // inside, between keys
      send_request(OP_RANGE,  8'h00, '0);          // equal to first key
      send_request(OP_RANGE,  8'hff, '0);          // equal to last key
      send_request(OP_CHANGE, 8'h80, 48'haaaa_aaaa_aaaa);
      send_request(OP_LOOKUP, 8'h80, '0);
      send_request(OP_CHANGE, 8'h41, '1);          // miss
      send_request(OP_REMOVE, 8'h00, '0);          // first entry
      send_request(OP_REMOVE, 8'hff, '0);          // last entry
      send_request(OP_REMOVE, 8'h80, '0);          // back to empty
      send_request(OP_RANGE,  8'h80, '0);
   endtask

   // fill to capacity, probe the full node, then drain it
   task automatic test_full_node();
      logic [KEY_W-1:0] k;
      int i;
      while (node_used < ENTRIES) begin
         k = KEY_W'($urandom);
         if (find_key(k) < 0) send_request(OP_INSERT, k, random_child());
      end
      do k = KEY_W'($urandom); while (find_key(k) >= 0);
      send_request(OP_INSERT, k, random_child());                  // full
      send_request(OP_INSERT, node_keys[$urandom_range(0, ENTRIES - 1)],
                   random_child());                                 // full beats duplicate
      for (i = 0; i < 6; i++) send_request(OP_RANGE, pick_key(), '0);
      for (i = 0; i < 4; i++) send_request(OP_LOOKUP, pick_key(), '0);
      send_request(OP_CHANGE, pick_key(), random_child());
      send_request(OP_REMOVE, node_keys[ENTRIES / 2], '0);
      send_request(OP_INSERT, k, random_child());
      while (node_used > 0) begin
         if ($urandom_range(0, 5) == 0) send_request(OP_REMOVE, KEY_W'($urandom), '0);
         else send_request(OP_REMOVE, node_keys[$urandom_range(0, node_used - 1)], '0);
      end
   endtask

   // random mix; insert and remove odds follow the fill level so the node
   // swings between empty and full
   task automatic test_random_mix(input int items);
      int pick;
      int ins_pct;
      int rem_pct;
      for (int n = 0; n < items; n++) begin
         ins_pct = (node_used < 4) ? 50 : (node_used > 13) ? 15 : 30;
         rem_pct = (node_used < 4) ? 10 : (node_used > 13) ? 35 : 20;
         pick = $urandom_range(0, 99);
         if (pick < ins_pct)
            send_request(OP_INSERT, pick_key(), random_child());
         else if (pick < ins_pct + rem_pct)
            send_request(OP_REMOVE, pick_key(), '0);
         else if (pick < ins_pct + rem_pct + 15)
            send_request(OP_CHANGE, pick_key(), random_child());
         else if (pick < ins_pct + rem_pct + 30)
            send_request(OP_LOOKUP, pick_key(), random_child());
         else
            send_request(OP_RANGE, pick_key(), random_child());
      end
   endtask

   initial begin
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      test_directed();
      test_random_mix(600);
      test_full_node();
      test_random_mix(400);
      test_full_node();
      // closing stretch runs back to back on both sides
      idling_on = 1'b0;
      test_random_mix(220);
      req_tvalid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (fail_count == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule
